/* design/aist_pkg.sv */
// aist_pkg: shared types, register codes and constants for the analog input
// scale or trigger block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package aist_pkg;

    // input sample width default
    localparam int SAMPLE_BITS_DEF = 10;

    // field widths
    localparam int IN_W   = 11;
    localparam int OUT_W  = 16;

    // datapath widths of the linear map
    localparam int DIN_W  = IN_W + 1;              // clamped sample minus floor
    localparam int DOUT_W = OUT_W + 1;             // out_high minus out_low
    localparam int PROD_W = DIN_W + DOUT_W;        // signed product
    localparam int DVD_W  = PROD_W - 2;            // product magnitude bits
    localparam int DVS_W  = IN_W;                  // span magnitude bits
    localparam int QUO_W  = OUT_W + 1;             // used quotient bits

    // configuration port
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // register reset values
    localparam logic [IN_W-1:0]         IN_LOW_RST   = IN_W'(0);
    localparam logic [IN_W-1:0]         IN_HIGH_RST  = IN_W'(1024);
    localparam logic signed [OUT_W-1:0] OUT_LOW_RST  = OUT_W'(0);
    localparam logic signed [OUT_W-1:0] OUT_HIGH_RST = OUT_W'(1023);

    // register indexes
    typedef enum logic [2:0] {
        REG_ENABLED  = 3'd0,
        REG_MODE     = 3'd1,
        REG_IN_LOW   = 3'd2,
        REG_IN_HIGH  = 3'd3,
        REG_OUT_LOW  = 3'd4,
        REG_OUT_HIGH = 3'd5
    } reg_idx_t;

    // channel mode
    typedef enum logic {
        MODE_SCALE   = 1'b0,
        MODE_TRIGGER = 1'b1
    } mode_t;

    // configuration bundle
    typedef struct packed {
        logic                    enabled;
        mode_t                   mode;
        logic [IN_W-1:0]         in_low;
        logic [IN_W-1:0]         in_high;
        logic signed [OUT_W-1:0] out_low;
        logic signed [OUT_W-1:0] out_high;
    } cfg_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_START,
        S_DIV,
        S_WRITE
    } state_t;

endpackage

`default_nettype wire

/* design/analog_input_scale_or_trigger_top.sv */
// analog_input_scale_or_trigger_top: one analog channel, linear range map or
// hysteresis trigger, with sequencer, multiplier and divider
// depends on aist_pkg, aist_regs, aist_div
// sequence: trigger mode evaluates, then writes; scale mode evaluates, sets up
//   the sign, runs 27 divider steps, takes the done and writes; a zero span
//   skips the divider; one request at a time, taken in idle after the result
//   has moved to the output register
// reset: rst_n async active low clears control, state, output and configuration registers to defaults
`timescale 1ns / 1ps
`default_nettype none

module analog_input_scale_or_trigger_top
    import aist_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_AW-1:0]      paddr,
    input  wire logic [APB_DW-1:0]      pwdata,
    output logic      [APB_DW-1:0]      prdata,
    output logic                        pready,
    // sample channel
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    // result channel
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic signed [OUT_W-1:0]     level,
    output logic                        note_off,
    output logic                        changed
);

    localparam int CMP_W = (SAMPLE_BITS > IN_W) ? SAMPLE_BITS : IN_W;

    cfg_t   cfg;
    state_t state_reg, state_next;

    // sequencer outputs
    logic   div_start;
    logic   out_load;

    // channel state
    logic signed [OUT_W-1:0] last_level_reg;
    logic                    below_floor_reg;
    logic                    armed_reg;

    // working registers
    logic [SAMPLE_BITS-1:0]   sample_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [DIN_W-1:0]  span_reg;
    logic                     neg_reg;
    logic signed [OUT_W-1:0]  res_level_reg;
    logic                     res_below_reg;
    logic                     res_armed_reg;
    logic                     res_chg_reg;

    // output register
    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] level_reg;
    logic                    note_off_reg;
    logic                    changed_reg;

    // evaluate-stage logic
    logic [CMP_W-1:0]         s_ext, lo_ext, hi_ext;
    logic                     s_below, s_above, s_at_high;
    logic [IN_W-1:0]          v_clamp;
    logic signed [DIN_W-1:0]  d_in;
    logic signed [DOUT_W-1:0] d_out;
    logic signed [PROD_W-1:0] prod;
    logic signed [DIN_W-1:0]  span;

    // divider interface
    logic [PROD_W-1:0] prod_mag;
    logic [DIN_W-1:0]  span_mag;
    logic              div_busy;
    logic              div_done;
    logic [DVD_W-1:0]  div_quo;

    // level from quotient
    logic signed [QUO_W:0]   q_signed;
    logic signed [QUO_W:0]   lvl_sum;
    logic signed [OUT_W-1:0] lvl_new;
    logic                    lvl_chg;

    aist_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    aist_div #(
        .NUM_W (DVD_W),
        .DEN_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_mag[DVD_W-1:0]),
        .divisor  (span_mag[DVS_W-1:0]),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // compares, clamp and product operands
    assign s_ext     = CMP_W'(sample_reg);
    assign lo_ext    = CMP_W'(cfg.in_low);
    assign hi_ext    = CMP_W'(cfg.in_high);
    assign s_below   = s_ext < lo_ext;
    assign s_above   = s_ext > hi_ext;
    assign s_at_high = s_ext >= hi_ext;
    assign v_clamp   = s_below ? cfg.in_low : (s_above ? cfg.in_high : s_ext[IN_W-1:0]);
    assign d_in      = $signed({1'b0, v_clamp}) - $signed({1'b0, cfg.in_low});
    assign d_out     = $signed({cfg.out_high[OUT_W-1], cfg.out_high})
                     - $signed({cfg.out_low[OUT_W-1], cfg.out_low});
    assign prod      = d_in * d_out;
    assign span      = $signed({1'b0, cfg.in_high}) - $signed({1'b0, cfg.in_low});

    // magnitudes for the divider
    assign prod_mag = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign span_mag = span_reg[DIN_W-1] ? DIN_W'(-span_reg) : DIN_W'(span_reg);

    // signed quotient plus floor output
    assign q_signed = neg_reg ? -$signed({1'b0, div_quo[QUO_W-1:0]})
                              : $signed({1'b0, div_quo[QUO_W-1:0]});
    assign lvl_sum  = $signed({{2{cfg.out_low[OUT_W-1]}}, cfg.out_low}) + q_signed;
    assign lvl_new  = lvl_sum[OUT_W-1:0];
    assign lvl_chg  = (lvl_new != last_level_reg) || (res_below_reg != below_floor_reg);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and sequencer outputs
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (!cfg.enabled)
                    state_next = S_IDLE;
                else if (cfg.mode == MODE_TRIGGER)
                    state_next = S_WRITE;
                else
                    state_next = S_START;
            end
            S_START:
            begin
                if (span_reg == '0)
                    state_next = S_WRITE;
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // working datapath
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            sample_reg <= sample;

        unique case (state_reg)
            S_EVAL:
            begin
                prod_reg      <= prod;
                span_reg      <= span;
                res_armed_reg <= armed_reg;
                res_level_reg <= last_level_reg;
                res_chg_reg   <= 1'b0;
                if (cfg.mode == MODE_TRIGGER)
                begin
                    res_below_reg <= below_floor_reg;
                    if (s_at_high)
                    begin
                        if (!armed_reg)
                        begin
                            res_armed_reg <= 1'b1;
                            res_level_reg <= OUT_W'(1);
                            res_chg_reg   <= 1'b1;
                        end
                    end
                    else if (s_below)
                    begin
                        if (armed_reg)
                        begin
                            res_armed_reg <= 1'b0;
                            res_level_reg <= '0;
                            res_chg_reg   <= 1'b1;
                        end
                    end
                end
                else
                    res_below_reg <= s_below;
            end
            S_START:
            begin
                neg_reg <= prod_reg[PROD_W-1] ^ span_reg[DIN_W-1];
                // zero span maps every sample to the floor output
                if (span_reg == '0)
                begin
                    res_level_reg <= cfg.out_low;
                    res_chg_reg   <= (cfg.out_low != last_level_reg)
                                  || (res_below_reg != below_floor_reg);
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_level_reg <= lvl_new;
                    res_chg_reg   <= lvl_chg;
                end
            end
            default: ;
        endcase
    end

    // channel state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg  <= '0;
            below_floor_reg <= 1'b0;
            armed_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            level_reg       <= '0;
            note_off_reg    <= 1'b0;
            changed_reg     <= 1'b0;
        end
        else if (out_load)
        begin
            last_level_reg  <= res_level_reg;
            below_floor_reg <= res_below_reg;
            armed_reg       <= res_armed_reg;
            out_valid_reg   <= 1'b1;
            level_reg       <= res_level_reg;
            note_off_reg    <= res_below_reg;
            changed_reg     <= res_chg_reg;
        end
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;
    assign level     = level_reg;
    assign note_off  = note_off_reg;
    assign changed   = changed_reg;

    // divider is never running while a new request can enter
    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !div_busy)
        else $error("divider busy while idle");

    // divider finishes only while the sequencer waits for it
    a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider done outside wait state");

    // divider never starts on a zero span
    a_span_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (span_reg != '0))
        else $error("divide by zero started");

    // channel state moves only when a result is written out
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !out_load |=> ($stable(armed_reg) && $stable(last_level_reg)
                       && $stable(below_floor_reg)))
        else $error("channel state changed without a result");

endmodule

`default_nettype wire

/* design/aist_regs.sv */
// aist_regs: configuration register file behind the APB-style port
// depends on aist_pkg
`timescale 1ns / 1ps
`default_nettype none

module aist_regs
    import aist_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    // address decode
    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled  <= 1'b0;
            cfg_reg.mode     <= MODE_SCALE;
            cfg_reg.in_low   <= IN_LOW_RST;
            cfg_reg.in_high  <= IN_HIGH_RST;
            cfg_reg.out_low  <= OUT_LOW_RST;
            cfg_reg.out_high <= OUT_HIGH_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_ENABLED:  cfg_reg.enabled  <= pwdata[0];
                REG_MODE:     cfg_reg.mode     <= mode_t'(pwdata[0]);
                REG_IN_LOW:   cfg_reg.in_low   <= pwdata[IN_W-1:0];
                REG_IN_HIGH:  cfg_reg.in_high  <= pwdata[IN_W-1:0];
                REG_OUT_LOW:  cfg_reg.out_low  <= pwdata[OUT_W-1:0];
                REG_OUT_HIGH: cfg_reg.out_high <= pwdata[OUT_W-1:0];
                default:      ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            REG_ENABLED:  prdata = {{(APB_DW-1){1'b0}}, cfg_reg.enabled};
            REG_MODE:     prdata = {{(APB_DW-1){1'b0}}, cfg_reg.mode};
            REG_IN_LOW:   prdata = {{(APB_DW-IN_W){1'b0}}, cfg_reg.in_low};
            REG_IN_HIGH:  prdata = {{(APB_DW-IN_W){1'b0}}, cfg_reg.in_high};
            REG_OUT_LOW:  prdata = {{(APB_DW-OUT_W){1'b0}}, cfg_reg.out_low};
            REG_OUT_HIGH: prdata = {{(APB_DW-OUT_W){1'b0}}, cfg_reg.out_high};
            default:      prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* design/aist_div.sv */
// aist_div: iterative restoring divider for unsigned magnitudes, one
// quotient bit per cycle
// depends on aist_pkg
`timescale 1ns / 1ps
`default_nettype none

module aist_div
    import aist_pkg::*;
#(
    parameter int NUM_W = DVD_W,
    parameter int DEN_W = DVS_W
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output logic                  busy,
    output logic                  done,
    output logic      [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] dvd_reg;
    logic [DEN_W-1:0] dvs_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_diff;
    logic             ge;

    // one restoring step
    assign rem_sh   = {rem_reg, dvd_reg[NUM_W-1]};
    assign ge       = rem_sh >= {1'b0, dvs_reg};
    assign rem_diff = rem_sh - {1'b0, dvs_reg};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: quotient bits shift into the low end of the dividend
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

`default_nettype wire
